// ===== rtl/core/ppc_pkg.sv =====
// ============================================================================
// ppc_pkg - protected path prefix check package
// Shared constants, the prefix table and the types passed between the top
// level and the match cells.
// ============================================================================
package ppc_pkg;

    localparam int NUM_PREFIXES   = 5;
    localparam int MAX_PREFIX_LEN = 16;
    localparam int POS_W          = 5;
    localparam int IDX_W          = 3;
    localparam logic [POS_W-1:0] POS_MAX  = 5'd31;
    localparam logic [7:0]       SEP_CHAR = 8'h2F;
    localparam logic [7:0]       NUL_CHAR = 8'h00;

    // per-beat broadcast from the top level to every cell
    typedef struct packed {
        logic             accept;
        logic             last;
        logic [POS_W-1:0] pos;
        logic [7:0]       char_in;
    } t_cell_ctl;

    // best match so far, handed down the chain of cells
    typedef struct packed {
        logic [POS_W-1:0] len;
        logic [IDX_W-1:0] idx;
    } t_best;

    function automatic logic [POS_W-1:0] prefix_len(input int idx);
        logic [POS_W-1:0] len;
        case (idx)
            0:       len = 5'd7;
            1:       len = 5'd12;
            2:       len = 5'd5;
            3:       len = 5'd14;
            4:       len = 5'd11;
            default: len = '0;
        endcase
        return len;
    endfunction

    // byte at position pos of prefix idx, zero beyond its end
    function automatic logic [7:0] prefix_char(input int idx, input logic [POS_W-1:0] pos);
        logic [8*MAX_PREFIX_LEN-1:0] str;
        int                          len;
        logic [7:0]                  ch;
        case (idx)
            0:       str = "/system";
            1:       str = "/system/keys";
            2:       str = "/boot";
            3:       str = "/data/packages";
            4:       str = "/data/users";
            default: str = '0;
        endcase
        len = int'(prefix_len(idx));
        ch  = NUL_CHAR;
        if (int'(pos) < len) begin
            ch = str[8*(len-1-int'(pos)) +: 8];
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/ppc_cell.sv =====
// ============================================================================
// ppc_cell - one prefix match cell
// Tracks one table entry against the incoming path and passes the longest
// hit so far on to the next cell.
// ============================================================================
module ppc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppc_pkg::t_cell_ctl i_ctl,
    input  ppc_pkg::t_best    i_best,
    output ppc_pkg::t_best    o_best
);

    localparam logic [ppc_pkg::POS_W-1:0] PrefixLen = ppc_pkg::prefix_len(CELL_IDX);
    localparam logic [ppc_pkg::IDX_W-1:0] EntryId   = ppc_pkg::IDX_W'(CELL_IDX + 1);

    logic       r_still, n_still;
    logic       r_bound, n_bound;
    logic [7:0] ref_char;
    logic       ends_here;
    logic       hit;

    always_comb begin
        ref_char  = ppc_pkg::prefix_char(CELL_IDX, i_ctl.pos);
        n_still   = r_still;
        n_bound   = r_bound;
        ends_here = 1'b0;
        if (i_ctl.pos < PrefixLen) begin
            if (i_ctl.pos >= ppc_pkg::POS_W'(ppc_pkg::MAX_PREFIX_LEN) ||
                i_ctl.char_in != ref_char) begin
                n_still = 1'b0;
            end else if (i_ctl.pos + ppc_pkg::POS_W'(1) == PrefixLen && r_still) begin
                ends_here = 1'b1;
            end
        end else if (i_ctl.pos == PrefixLen) begin
            if (r_still && (i_ctl.char_in == ppc_pkg::SEP_CHAR ||
                            i_ctl.char_in == ppc_pkg::NUL_CHAR)) begin
                n_bound = 1'b1;
            end
        end
        hit = n_bound | ends_here;
        // strictly longer wins, so the lower entry keeps a tie
        if (hit && PrefixLen > i_best.len) begin
            o_best.len = PrefixLen;
            o_best.idx = EntryId;
        end else begin
            o_best = i_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_still <= 1'b1;
            r_bound <= 1'b0;
        end else if (i_ctl.accept) begin
            if (i_ctl.last) begin
                r_still <= 1'b1;
                r_bound <= 1'b0;
            end else begin
                r_still <= n_still;
                r_bound <= n_bound;
            end
        end
    end

endmodule

// ===== rtl/core/protected_path_prefix_check_top.sv =====
// ============================================================================
// protected_path_prefix_check_top - protected path prefix check
// Matches a byte-serial path against the protected prefix table and returns
// the longest matching entry and the write verdict on the final byte.
// ============================================================================
// The block takes one path byte per beat, one beat per cycle back to back,
// and returns one result beat for the byte marked last in the cycle after that
// byte is accepted. The rate is set by the row of match cells: each cell owns
// one table entry, compares the incoming byte against its entry's byte at the
// current position in the same cycle, and hands the longest hit so far to
// the next cell. A result waits in the output register while the consumer
// stalls; the input stalls only while that register is full and stalled.
// The caller bits (no_process, priv_active, pid_is_zero) are sampled on the
// last byte only. i_cfg_wdata sets strict mode, in which pid zero no longer
// bypasses the protection; write it only while no path is in flight.
module protected_path_prefix_check_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // path byte channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_path_char,
    input  logic       i_last_char,
    input  logic       i_no_process,
    input  logic       i_priv_active,
    input  logic       i_pid_is_zero,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_is_protected,
    output logic [2:0] o_matched_entry,
    output logic       o_denied
);

    localparam int NumCells = ppc_pkg::NUM_PREFIXES;

    logic                          r_strict;
    logic [ppc_pkg::POS_W-1:0]     r_pos;
    logic                          r_out_valid;
    logic                          r_is_protected;
    logic [ppc_pkg::IDX_W-1:0]     r_matched_entry;
    logic                          r_denied;

    logic                          accept;
    logic                          privileged;
    logic                          n_prot;
    ppc_pkg::t_cell_ctl            cell_ctl;
    ppc_pkg::t_best                best_chain [NumCells+1];

    // hold input while a finished result is stuck at the output
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign cell_ctl.accept  = accept;
    assign cell_ctl.last    = i_last_char;
    assign cell_ctl.pos     = r_pos;
    assign cell_ctl.char_in = i_path_char;

    // head of the chain: no match yet
    assign best_chain[0] = '0;

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        ppc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_best  (best_chain[g]),
            .o_best  (best_chain[g+1])
        );
    end

    assign n_prot     = best_chain[NumCells].idx != '0;
    assign privileged = i_no_process | i_priv_active | (~r_strict & i_pid_is_zero);

    // strict mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
        end else if (i_cfg_we) begin
            r_strict <= i_cfg_wdata;
        end
    end

    // advance byte position, saturate on long paths, clear after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            if (i_last_char) begin
                r_pos <= '0;
            end else if (r_pos != ppc_pkg::POS_MAX) begin
                r_pos <= r_pos + ppc_pkg::POS_W'(1);
            end
        end
    end

    // result register: load on the last byte, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_last_char) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_char) begin
            r_is_protected  <= n_prot;
            r_matched_entry <= best_chain[NumCells].idx;
            r_denied        <= n_prot & ~privileged;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_protected  = r_is_protected;
    assign o_matched_entry = r_matched_entry;
    assign o_denied        = r_denied;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_denied_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_denied |-> o_is_protected)
        else $error("denied without a protected match");

    a_entry_agrees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_protected == (o_matched_entry != '0)))
        else $error("is_protected disagrees with matched_entry");

    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_matched_entry <= ppc_pkg::IDX_W'(ppc_pkg::NUM_PREFIXES)))
        else $error("matched_entry out of range");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_last_char && r_pos != ppc_pkg::POS_MAX
        |=> r_pos == $past(r_pos) + ppc_pkg::POS_W'(1))
        else $error("position did not advance");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_char |=> r_pos == '0 && o_out_valid)
        else $error("last byte did not clear position or raise a result");

endmodule

// ===== tb/protected_path_prefix_check_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// protected_path_prefix_check_top_tb - self-checking bench for the path check
// Streams directed and random paths in one byte per beat, works out each verdict
// not typed by hand from a private copy of the prefix table and match state,
// and checks each result beat in order while both channels idle and stall.
// ============================================================================
module protected_path_prefix_check_top_tb;

    // matched_entry codes, 1-based in table order
    localparam logic [ppc_pkg::IDX_W-1:0] ENTRY_NONE     = 3'd0;
    localparam logic [ppc_pkg::IDX_W-1:0] ENTRY_SYSTEM   = 3'd1;
    localparam logic [ppc_pkg::IDX_W-1:0] ENTRY_KEYS     = 3'd2;
    localparam logic [ppc_pkg::IDX_W-1:0] ENTRY_BOOT     = 3'd3;
    localparam logic [ppc_pkg::IDX_W-1:0] ENTRY_PACKAGES = 3'd4;
    localparam logic [ppc_pkg::IDX_W-1:0] ENTRY_USERS    = 3'd5;

    localparam int TAIL_CYCLES     = 4;
    localparam int RANDOM_PHASES   = 4;
    localparam int PHASE_BEATS     = 300;
    localparam int HOLD_OFF_BEATS  = 280;  // accepted bytes before the long output stall
    localparam int HOLD_OFF_CYCLES = 200;

    typedef struct packed {
        logic                      prot;
        logic [ppc_pkg::IDX_W-1:0] entry;
        logic                      den;
    } t_verdict;

    typedef struct {
        string    path;
        bit       nul_tail;   // append a zero byte after the text
        bit       strict;
        bit       np;
        bit       pa;
        bit       pz;
        bit       typed;      // want holds the verdict read off by hand
        t_verdict want;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_wdata;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [7:0]       i_path_char;
    logic             i_last_char;
    logic             i_no_process;
    logic             i_priv_active;
    logic             i_pid_is_zero;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_is_protected;
    logic [2:0]       o_matched_entry;
    logic             o_denied;

    // hand-typed verdict riding along with the current beat
    logic             beat_typed;
    t_verdict         beat_want;

    // private copy of the protected prefix table
    string guard_prefix [ppc_pkg::NUM_PREFIXES] = '{"/system", "/system/keys", "/boot",
                                                    "/data/packages", "/data/users"};
    string tail_chars = "/abceksy";

    // shadow of the block's per-path match state and strict mode
    logic [ppc_pkg::POS_W-1:0]        byte_pos;
    logic [ppc_pkg::NUM_PREFIXES-1:0] live_mask;
    logic [ppc_pkg::NUM_PREFIXES-1:0] boundary_hits;
    logic                             strict_shadow;

    t_verdict pending_verdicts [$];
    int       fail_count = 0;
    int       beats_in   = 0;

    // directed paths: extremes, every entry, boundary rules, caller kinds
    t_dir_row dir_tab [16] = '{
        '{"/boot",           0, 0, 0, 0, 0, 1, '{1'b1, ENTRY_BOOT,     1'b1}},
        '{"/system/keys",    0, 0, 0, 0, 0, 1, '{1'b1, ENTRY_KEYS,     1'b1}},
        '{"/system/keysx",   0, 0, 0, 0, 0, 0, '{1'b0, ENTRY_NONE,     1'b0}},
        '{"/data/packages",  0, 0, 0, 0, 1, 1, '{1'b1, ENTRY_PACKAGES, 1'b0}},
        '{"/data/users/a",   0, 0, 0, 1, 0, 1, '{1'b1, ENTRY_USERS,    1'b0}},
        '{"/systemd",        0, 0, 0, 0, 0, 1, '{1'b0, ENTRY_NONE,     1'b0}},
        '{"/boot",           1, 0, 1, 0, 0, 0, '{1'b0, ENTRY_NONE,     1'b0}},
        '{"\377",            0, 0, 0, 0, 0, 1, '{1'b0, ENTRY_NONE,     1'b0}},
        '{"",                1, 0, 1, 1, 1, 1, '{1'b0, ENTRY_NONE,     1'b0}},
        '{"boot",            0, 0, 0, 0, 0, 1, '{1'b0, ENTRY_NONE,     1'b0}},
        '{"/dat",            0, 0, 0, 0, 0, 0, '{1'b0, ENTRY_NONE,     1'b0}},
        '{"/data/users/abcdefghijklmnopqrstuvwxyz0",
                             0, 0, 0, 0, 0, 0, '{1'b0, ENTRY_NONE,     1'b0}},
        '{"/system",         0, 1, 0, 0, 1, 1, '{1'b1, ENTRY_SYSTEM,   1'b1}},
        '{"/system/",        0, 1, 1, 0, 0, 1, '{1'b1, ENTRY_SYSTEM,   1'b0}},
        '{"/system/keys/x",  0, 1, 0, 0, 1, 0, '{1'b0, ENTRY_NONE,     1'b0}},
        '{"/system",         0, 0, 0, 0, 1, 1, '{1'b1, ENTRY_SYSTEM,   1'b0}}
    };

    protected_path_prefix_check_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_path_char     (i_path_char),
        .i_last_char     (i_last_char),
        .i_no_process    (i_no_process),
        .i_priv_active   (i_priv_active),
        .i_pid_is_zero   (i_pid_is_zero),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_is_protected  (o_is_protected),
        .o_matched_entry (o_matched_entry),
        .o_denied        (o_denied)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #1_000_000;
        $display("protected_path_prefix_check_top_tb: FAIL");
        $finish;
    end

    function automatic void clear_path();
        byte_pos      = '0;
        live_mask     = '1;
        boundary_hits = '0;
    endfunction

    // Advance the match state by one byte; on the last byte return 1 and the verdict.
    function automatic bit path_verdict(input logic [7:0] ch, input logic last,
                                        input logic np, input logic pa, input logic pz,
                                        output t_verdict v);
        logic [ppc_pkg::NUM_PREFIXES-1:0] ends_now;
        logic [7:0]                       want_ch;
        logic [ppc_pkg::IDX_W-1:0]        top_idx;
        logic                             privileged;
        int                               plen;
        int                               top_len;
        ends_now = '0;
        top_idx  = ENTRY_NONE;
        top_len  = 0;
        v        = '0;
        for (int k = 0; k < ppc_pkg::NUM_PREFIXES; k++) begin
            plen = guard_prefix[k].len();
            if (int'(byte_pos) < plen) begin
                want_ch = guard_prefix[k][byte_pos];
                if (ch != want_ch) begin
                    live_mask[k] = 1'b0;
                end else if (int'(byte_pos) + 1 == plen && live_mask[k]) begin
                    ends_now[k] = 1'b1;
                end
            end else if (int'(byte_pos) == plen && live_mask[k] &&
                         (ch == ppc_pkg::SEP_CHAR || ch == ppc_pkg::NUL_CHAR)) begin
                // a separator or a string end right past the prefix closes a component
                boundary_hits[k] = 1'b1;
            end
        end
        if (!last) begin
            if (byte_pos != ppc_pkg::POS_MAX) begin
                byte_pos++;
            end
            return 1'b0;
        end
        // longest hit wins; strict compare keeps the lower index on a tie
        for (int k = 0; k < ppc_pkg::NUM_PREFIXES; k++) begin
            plen = guard_prefix[k].len();
            if ((boundary_hits[k] || ends_now[k]) && plen > top_len) begin
                top_len = plen;
                top_idx = ppc_pkg::IDX_W'(k + 1);
            end
        end
        privileged = np || pa || (!strict_shadow && pz);
        v.prot     = (top_idx != ENTRY_NONE);
        v.entry    = top_idx;
        v.den      = v.prot && !privileged;
        clear_path();
        return 1'b1;
    endfunction

    function automatic void check_field(input string field, input logic [2:0] want,
                                        input logic [2:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, field, want, got);
        end
    endfunction

    // Sample both channels at the rising edge: predict on input beats, check on output beats.
    always @(posedge i_clk) begin
        t_verdict calc;
        t_verdict want;
        if (!i_rst_n) begin
            strict_shadow = 1'b0;
            clear_path();
        end else begin
            if (i_cfg_we) begin
                strict_shadow = i_cfg_wdata;
            end
            if (i_in_valid && !o_in_stall) begin
                beats_in++;
                if (path_verdict(i_path_char, i_last_char, i_no_process, i_priv_active,
                                 i_pid_is_zero, calc)) begin
                    pending_verdicts.push_back(beat_typed ? beat_want : calc);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    fail_count++;
                    $display({"%0t ns: result beat with no verdict pending, ",
                              "expected none, got entry %0d"}, $time, o_matched_entry);
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("is_protected",  {2'b00, want.prot}, {2'b00, o_is_protected});
                    check_field("matched_entry", want.entry,         o_matched_entry);
                    check_field("denied",        {2'b00, want.den},  {2'b00, o_denied});
                end
            end
        end
    end

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 70) begin
            return 0;
        end
        return (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    // Offer one byte after an optional gap and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] ch, input logic last, input logic np,
                             input logic pa, input logic pz, input logic typed,
                             input t_verdict want, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_path_char   <= ch;
        i_last_char   <= last;
        i_no_process  <= np;
        i_priv_active <= pa;
        i_pid_is_zero <= pz;
        beat_typed    <= typed;
        beat_want     <= want;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) begin
                break;
            end
        end
    endtask

    // Drop valid and wait until every pending verdict has come back.
    task automatic settle_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_strict(input logic mode);
        settle_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Output side: random stall runs, plus one long hold-off that backs up the input.
    initial begin
        int  run;
        bit  squeezed;
        squeezed    = 1'b0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            run = $urandom_range(0, 9);
            if (!squeezed && beats_in >= HOLD_OFF_BEATS) begin
                squeezed = 1'b1;
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else if (run < 4) begin
                @(negedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end else if (run < 8) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat ($urandom_range(0, 2)) @(negedge i_clk);
            end else begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat ($urandom_range(7, 39)) @(negedge i_clk);
            end
        end
    end

    // Input side: reset, directed table, then random phases with strict mode toggling.
    initial begin
        logic [7:0] path_bytes [$];
        t_dir_row   row;
        string      base;
        logic       np;
        logic       pa;
        logic       pz;
        int         kind;
        int         pick;
        int         cut;
        int         tail_len;
        int         gap_mode;
        int         sent;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        i_in_valid    = 1'b0;
        i_path_char   = 8'h00;
        i_last_char   = 1'b0;
        i_no_process  = 1'b0;
        i_priv_active = 1'b0;
        i_pid_is_zero = 1'b0;
        beat_typed    = 1'b0;
        beat_want     = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_strict(1'b0);
        foreach (dir_tab[r]) begin
            row = dir_tab[r];
            if (row.strict != strict_shadow) begin
                write_strict(row.strict);
            end
            path_bytes.delete();
            for (int k = 0; k < row.path.len(); k++) begin
                path_bytes.push_back(row.path[k]);
            end
            if (row.nul_tail) begin
                path_bytes.push_back(ppc_pkg::NUL_CHAR);
            end
            foreach (path_bytes[k]) begin
                send_byte(path_bytes[k], k == path_bytes.size() - 1, row.np, row.pa, row.pz,
                          row.typed, row.want, 0);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_strict(ph % 2 == 0);
            sent = 0;
            while (sent < PHASE_BEATS) begin
                path_bytes.delete();
                kind = $urandom_range(0, 99);
                if (kind < 75) begin
                    // well-formed: a table prefix, sometimes cut or corrupted, then a tail
                    base = guard_prefix[$urandom_range(0, ppc_pkg::NUM_PREFIXES - 1)];
                    cut  = base.len();
                    if ($urandom_range(0, 9) == 0) begin
                        cut = $urandom_range(1, base.len());
                    end
                    for (int k = 0; k < cut; k++) begin
                        path_bytes.push_back(base[k]);
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        path_bytes[$urandom_range(0, cut - 1)] = 8'($urandom_range(0, 255));
                    end
                    tail_len = (kind < 5) ? $urandom_range(20, 34) : $urandom_range(0, 6);
                    pick     = $urandom_range(0, 9);
                    if (pick < 5) begin
                        path_bytes.push_back(ppc_pkg::SEP_CHAR);
                    end else if (pick == 5) begin
                        path_bytes.push_back(ppc_pkg::NUL_CHAR);
                    end else if (pick == 6) begin
                        tail_len = 0;
                    end else begin
                        path_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    for (int k = 0; k < tail_len; k++) begin
                        if ($urandom_range(0, 3) == 0) begin
                            path_bytes.push_back(8'($urandom_range(0, 255)));
                        end else begin
                            path_bytes.push_back(tail_chars[$urandom_range(0, 7)]);
                        end
                    end
                end else begin
                    // noise, short or running past the saturation point
                    tail_len = (kind < 95) ? $urandom_range(1, 10) : $urandom_range(30, 40);
                    for (int k = 0; k < tail_len; k++) begin
                        path_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        path_bytes[0] = ppc_pkg::SEP_CHAR;
                    end
                end
                np       = ($urandom_range(0, 3) == 0);
                pa       = ($urandom_range(0, 3) == 0);
                pz       = ($urandom_range(0, 2) == 0);
                gap_mode = $urandom_range(0, 3);
                foreach (path_bytes[k]) begin
                    send_byte(path_bytes[k], k == path_bytes.size() - 1, np, pa, pz,
                              1'b0, '0, pick_gap(gap_mode));
                end
                sent += path_bytes.size();
            end
        end

        settle_idle();
        if (fail_count == 0) begin
            $display("protected_path_prefix_check_top_tb: PASS");
        end else begin
            $display("protected_path_prefix_check_top_tb: FAIL");
        end
        $finish;
    end

endmodule
